>>> hw/rtl/vccm_pkg.sv
`timescale 1ns / 1ps
package vccm_pkg;
  localparam int DEFAULT_MAX_ENTRIES = 16;
  localparam logic [31:0] DEFAULT_JITTER = 32'd3600;

  localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] OP_COMPARE    = 2'd2;

  localparam logic [1:0] CFG_HORIZON = 2'd0;
  localparam logic [1:0] CFG_JITTER  = 2'd1;
  localparam logic [1:0] CFG_EMIT    = 2'd2;

  localparam logic [1:0] ANC_EQUAL = 2'd0;
  localparam logic [1:0] ANC_LEFT  = 2'd1;
  localparam logic [1:0] ANC_RIGHT = 2'd2;
  localparam logic [1:0] ANC_DIVERGE = 2'd3;

  typedef struct packed {
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [63:0] stamp;
    logic [31:0] tick;
  } vc_entry_t;

  // select which entry the datapath drives to the output register
  typedef enum logic [1:0] {
    SEL_LEFT,
    SEL_RIGHT,
    SEL_NONE
  } sel_t;

  // controller to datapath
  typedef struct packed {
    logic load_left;
    logic load_right;
    logic start;      // latch times, clear indexes and flags
    logic rd;         // issue a store read at current indexes
    logic step;       // evaluate registered read data
    logic clear;      // empty both stores
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic l_more;     // left index below count
    logic r_more;
    logic emit;       // step would produce an entry
  } dp_sts_t;
endpackage

>>> hw/rtl/vccm_datapath.sv
`timescale 1ns / 1ps
module vccm_datapath #(
  parameter int MAX_ENTRIES = vccm_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  vccm_pkg::dp_cmd_t   cmd,
  output vccm_pkg::dp_sts_t   sts,
  input  vccm_pkg::vc_entry_t in_entry,
  input  logic [63:0]         in_now,
  input  logic [31:0]         horizon,
  input  logic [31:0]         jitter_bound,
  output vccm_pkg::vc_entry_t emit_entry,
  output logic [1:0]          ancestry
);
  import vccm_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ENTRIES);

  vc_entry_t lmem [MAX_ENTRIES];
  vc_entry_t rmem [MAX_ENTRIES];
  vc_entry_t lrd_r, rrd_r;

  logic [CW-1:0] lcnt_r, rcnt_r, li_r, ri_r, li_nxt, ri_nxt;
  logic [63:0] ign_r, prn_r, ign_nxt;
  logic lmr_r, rmr_r, lmr_nxt, rmr_nxt;
  logic lm, rm, id_lt, id_gt, l_old, r_old, lgt_ign, rgt_ign, l_win, r_win;
  logic emit_hit;

  always_ff @(posedge clk) begin
    if (cmd.load_left && lcnt_r < CAP) lmem[lcnt_r[IW-1:0]] <= in_entry;
    if (cmd.load_right && rcnt_r < CAP) rmem[rcnt_r[IW-1:0]] <= in_entry;
    if (cmd.rd) begin
      lrd_r <= lmem[li_r[IW-1:0]];
      rrd_r <= rmem[ri_r[IW-1:0]];
    end
  end

  assign lm = li_r < lcnt_r;
  assign rm = ri_r < rcnt_r;
  assign id_lt = {lrd_r.id_high, lrd_r.id_low} < {rrd_r.id_high, rrd_r.id_low};
  assign id_gt = {lrd_r.id_high, lrd_r.id_low} > {rrd_r.id_high, rrd_r.id_low};
  assign l_old = lrd_r.stamp <= prn_r;
  assign r_old = rrd_r.stamp <= prn_r;
  assign lgt_ign = lrd_r.stamp > ign_r;
  assign rgt_ign = rrd_r.stamp > ign_r;
  assign r_win = lrd_r.stamp < rrd_r.stamp ||
                 (lrd_r.stamp == rrd_r.stamp && lrd_r.tick < rrd_r.tick);
  assign l_win = lrd_r.stamp > rrd_r.stamp || lrd_r.tick > rrd_r.tick;
  assign ign_nxt = in_now - {32'd0, horizon};

  // one walk step: choose entry and update indexes and recency flags
  always_comb begin
    sel_t sel;
    sel = SEL_NONE;
    li_nxt = li_r;
    ri_nxt = ri_r;
    lmr_nxt = lmr_r;
    rmr_nxt = rmr_r;
    if (lm && rm) begin
      if (id_lt) begin
        lmr_nxt = lmr_r | lgt_ign;
        if (!l_old) sel = SEL_LEFT;
        li_nxt = li_r + 1'b1;
      end else if (id_gt) begin
        rmr_nxt = rmr_r | rgt_ign;
        if (!r_old) sel = SEL_RIGHT;
        ri_nxt = ri_r + 1'b1;
      end else begin
        if (!(l_old && r_old)) begin
          if (r_win) begin
            rmr_nxt = rmr_r | rgt_ign;
            sel = SEL_RIGHT;
          end else if (l_win) begin
            lmr_nxt = lmr_r | lgt_ign;
            sel = SEL_LEFT;
          end else begin
            sel = SEL_LEFT;
          end
        end
        li_nxt = li_r + 1'b1;
        ri_nxt = ri_r + 1'b1;
      end
    end else if (lm) begin
      if (!l_old) begin
        lmr_nxt = lmr_r | lgt_ign;
        sel = SEL_LEFT;
      end
      li_nxt = li_r + 1'b1;
    end else if (rm) begin
      if (!r_old) begin
        rmr_nxt = rmr_r | rgt_ign;
        sel = SEL_RIGHT;
      end
      ri_nxt = ri_r + 1'b1;
    end
    case (sel)
      SEL_LEFT:  emit_entry = lrd_r;
      SEL_RIGHT: emit_entry = rrd_r;
      default:   emit_entry = lrd_r;
    endcase
    emit_hit = sel != SEL_NONE;
  end

  assign sts.emit = emit_hit;
  assign sts.l_more = lm;
  assign sts.r_more = rm;
  assign ancestry = (lmr_r && rmr_r) ? ANC_DIVERGE : lmr_r ? ANC_LEFT :
                    rmr_r ? ANC_RIGHT : ANC_EQUAL;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ign_r <= (horizon != 32'd0) ? ign_nxt : 64'd0;
      prn_r <= (horizon != 32'd0) ? ign_nxt - {32'd0, jitter_bound} : 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r <= '0;
      rcnt_r <= '0;
      li_r <= '0;
      ri_r <= '0;
      lmr_r <= 1'b0;
      rmr_r <= 1'b0;
    end else begin
      if (cmd.load_left && lcnt_r < CAP) lcnt_r <= lcnt_r + 1'b1;
      if (cmd.load_right && rcnt_r < CAP) rcnt_r <= rcnt_r + 1'b1;
      if (cmd.start) begin
        li_r <= '0;
        ri_r <= '0;
        lmr_r <= 1'b0;
        rmr_r <= 1'b0;
      end else if (cmd.step) begin
        li_r <= li_nxt;
        ri_r <= ri_nxt;
        lmr_r <= lmr_nxt;
        rmr_r <= rmr_nxt;
      end
      if (cmd.clear) begin
        lcnt_r <= '0;
        rcnt_r <= '0;
      end
    end
  end
endmodule

>>> hw/rtl/vccm_ctrl.sv
`timescale 1ns / 1ps
module vccm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_op,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              out_is_entry,
  output logic              out_load,
  input  logic              emit_merged,
  output vccm_pkg::dp_cmd_t cmd,
  input  vccm_pkg::dp_sts_t sts
);
  import vccm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_STEP,
    S_WAIT,
    S_FINAL
  } state_t;

  state_t state_r;
  logic   ov_r;
  logic   acc;
  logic   ofree;

  assign ofree = !ov_r || out_tready;
  assign in_tready = state_r == S_IDLE && ofree;
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = ov_r;

  always_comb begin
    cmd = '0;
    out_load = 1'b0;
    out_is_entry = 1'b0;
    cmd.load_left = acc && in_op == OP_LOAD_LEFT;
    cmd.load_right = acc && in_op == OP_LOAD_RIGHT;
    cmd.start = acc && in_op == OP_COMPARE;
    case (state_r)
      S_READ: cmd.rd = 1'b1;
      S_STEP: begin
        cmd.step = 1'b1;
        out_load = sts.emit && emit_merged;
        out_is_entry = 1'b1;
      end
      S_FINAL: if (ofree) begin
        out_load = 1'b1;
        cmd.clear = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      if (out_load) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (cmd.start) state_r <= S_WAIT;
        S_WAIT: if (ofree) state_r <= (sts.l_more || sts.r_more) ? S_READ : S_FINAL;
        S_READ: state_r <= S_STEP;
        S_STEP: state_r <= S_WAIT;
        S_FINAL: if (ofree) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/vector_clock_compare_merge_core.sv
`timescale 1ns / 1ps
// Vector clock compare and merge. Load items (left or right) fill two
// stores of MAX_ENTRIES entries; loads past capacity are dropped. A compare
// item walks both stores in id order through one store read port per side.
// One walk step covers one lone entry or one pair with matching ids, so a
// compare takes at most left+right steps. Each step waits for a free output
// register, then reads, then evaluates and launches; the final ancestry
// result waits for a free output register and then launches. No new input
// is accepted until the compare has finished. Merged entries (when enabled)
// and the ancestry result leave through a one-deep output register.
module vector_clock_compare_merge_core #(
  parameter int MAX_ENTRIES = vccm_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation, id_high, id_low, stamp, tick_count, now (lowest bits first)
  input  logic [295:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // entry_valid, out_id_high, out_id_low, out_stamp, out_tick, ancestry
  output logic [231:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import vccm_pkg::*;

  logic [31:0] horizon_r, jitter_r;
  logic        emit_r;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  vc_entry_t   in_entry, emit_entry;
  logic [1:0]  anc;
  logic        out_load, out_is_entry;
  logic [231:0] odata_r;
  logic        olast_r;

  // input unpack
  assign in_entry.id_high = in_tdata[65:2];
  assign in_entry.id_low  = in_tdata[129:66];
  assign in_entry.stamp   = in_tdata[193:130];
  assign in_entry.tick    = in_tdata[225:194];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= 32'd0;
      jitter_r <= DEFAULT_JITTER;
      emit_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HORIZON: horizon_r <= cfg_wdata;
        CFG_JITTER:  jitter_r <= cfg_wdata;
        CFG_EMIT:    emit_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  vccm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_op(in_tdata[1:0]),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_is_entry(out_is_entry), .out_load(out_load),
    .emit_merged(emit_r), .cmd(cmd), .sts(sts)
  );

  vccm_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_entry(in_entry), .in_now(in_tdata[289:226]),
    .horizon(horizon_r), .jitter_bound(jitter_r),
    .emit_entry(emit_entry), .ancestry(anc)
  );

  // output register: merged entry or final ancestry result
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (out_is_entry) begin
        odata_r <= {5'd0, 2'd0, emit_entry.tick, emit_entry.stamp,
                    emit_entry.id_low, emit_entry.id_high, 1'b1};
        olast_r <= 1'b0;
      end else begin
        odata_r <= {5'd0, anc, 224'd0, 1'b0};
        olast_r <= 1'b1;
      end
    end
  end

  assign out_tdata = odata_r;
  assign out_tlast = olast_r;
endmodule
